// ----- src/rsfp_pkg.sv -----
// shared types and constants for the radio i/o sample frame parser
package rsfp_pkg;

	// framing bytes
	localparam logic [7:0] FRAME_DELIM = 8'h7E;
	localparam logic [7:0] FRAME_TYPE_IO_SAMPLE = 8'h92;

	// shortest body that carries an i/o sample header
	localparam logic [15:0] MIN_SAMPLE_LEN = 16'd16;

	// analog defaults when a channel is absent
	localparam logic [15:0] ANALOG_DEFAULT_STICK = 16'd512;
	localparam logic [15:0] ANALOG_DEFAULT_WHEEL = 16'd0;

	// digital word bit positions of the buttons
	localparam int BTN_BIT_DIO5 = 5;
	localparam int BTN_BIT_DIO6 = 6;
	localparam int BTN_BIT_DIO10 = 10;
	localparam int BTN_BIT_DIO11 = 11;
	localparam int BTN_BIT_DIO4 = 4;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_REMOTE_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REMOTE_ADDR_ZERO = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_REMOTE_ADDR_ONE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_REMOTE_ADDR_TWO = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_REMOTE_ADDR_THREE = 3'd4;
	localparam int REMOTE_COUNT_W = 3;

	// fields of one parsed frame, handed to the result stage
	typedef struct packed {
		logic [31:0] sender;
		logic [15:0] digital_word;
		logic [3:0][15:0] analog;
	} frame_rec_t;

endpackage

// ----- src/rsfp_in_reg.sv -----
// input register stage holding one received byte
module rsfp_in_reg
	import rsfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// stage is free when empty or being drained this cycle
	assign in_ready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ----- src/rsfp_parser.sv -----
// byte-wise frame parser: delimiter hunt, length, body fields, checksum, skip of bad lengths
module rsfp_parser
	import rsfp_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] byte_in,
	input  logic       out_free,
	output logic       take,
	output logic       emit,
	output frame_rec_t frame
);

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_BYTES);

	// field cursor codes
	localparam logic [2:0] CUR_DIGITAL = 3'd0;
	localparam logic [2:0] CUR_DONE = 3'd5;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_BODY,
		PH_CHECK,
		PH_SKIP
	} phase_t;

	phase_t            phase_q;
	logic [15:0]       frame_len_q;
	logic [POS_W-1:0]  pos_q;
	logic [16:0]       skip_q;
	logic              kind_ok_q;
	logic [15:0]       dmask_q;
	logic [3:0]        amask_q;
	logic [7:0]        high_q;
	logic [2:0]        cursor_q;
	logic [31:0]       sender_q;
	logic [15:0]       dword_q;
	logic [3:0][15:0]  analog_q;

	logic [15:0]       len_full;
	logic [POS_W-1:0]  pos_next;
	logic              emit_cond;

	// next present field at or after a cursor position
	function automatic logic [2:0] find_field(input logic [2:0] from, input logic dig_nz,
			input logic [3:0] amask);
		logic [2:0] res;
		logic       found;
		res = CUR_DONE;
		found = 1'b0;
		for (int c = 0; c < 5; c++) begin
			if (!found && 3'(c) >= from) begin
				if (c == 0) begin
					if (dig_nz) begin
						res = 3'(c);
						found = 1'b1;
					end
				end else if (amask[2'(c - 1)]) begin
					res = 3'(c);
					found = 1'b1;
				end
			end
		end
		return res;
	endfunction

	assign len_full = {frame_len_q[15:8], byte_in};
	assign pos_next = pos_q + 1'b1;

	// a result leaves on the checksum byte of a complete sample frame
	assign emit_cond = (phase_q == PH_CHECK) && kind_ok_q && (frame_len_q >= MIN_SAMPLE_LEN)
		&& (cursor_q != CUR_DIGITAL);
	assign take = byte_valid && (!emit_cond || out_free);
	assign emit = take && emit_cond;

	assign frame.sender = sender_q;
	assign frame.digital_word = dword_q;
	assign frame.analog = analog_q;

	// parse state and frame fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			frame_len_q <= '0;
			pos_q <= '0;
			skip_q <= '0;
			kind_ok_q <= 1'b0;
			dmask_q <= '0;
			amask_q <= '0;
			high_q <= '0;
			cursor_q <= CUR_DONE;
			sender_q <= '0;
			dword_q <= '0;
			analog_q <= {ANALOG_DEFAULT_WHEEL, ANALOG_DEFAULT_WHEEL,
				ANALOG_DEFAULT_STICK, ANALOG_DEFAULT_STICK};
		end else if (take) begin
			case (phase_q)
				PH_HUNT: begin
					if (byte_in == FRAME_DELIM) begin
						phase_q <= PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					frame_len_q[15:8] <= byte_in;
					phase_q <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					frame_len_q <= len_full;
					if (len_full == 16'd0 || len_full > MAX_LEN) begin
						skip_q <= 17'(len_full) + 17'd1;
						phase_q <= PH_SKIP;
					end else begin
						// fresh frame
						pos_q <= '0;
						kind_ok_q <= 1'b0;
						sender_q <= '0;
						dmask_q <= '0;
						amask_q <= '0;
						dword_q <= '0;
						analog_q <= {ANALOG_DEFAULT_WHEEL, ANALOG_DEFAULT_WHEEL,
							ANALOG_DEFAULT_STICK, ANALOG_DEFAULT_STICK};
						high_q <= '0;
						cursor_q <= CUR_DONE;
						phase_q <= PH_BODY;
					end
				end
				PH_BODY: begin
					// header bytes
					if (pos_q == POS_W'(0)) begin
						kind_ok_q <= (byte_in == FRAME_TYPE_IO_SAMPLE);
					end else if (pos_q >= POS_W'(5) && pos_q <= POS_W'(8)) begin
						sender_q <= {sender_q[23:0], byte_in};
					end else if (pos_q == POS_W'(13)) begin
						dmask_q <= {byte_in, 8'd0};
					end else if (pos_q == POS_W'(14)) begin
						dmask_q[7:0] <= byte_in;
					end else if (pos_q == POS_W'(15)) begin
						amask_q <= byte_in[3:0];
						cursor_q <= find_field(CUR_DIGITAL, dmask_q != 16'd0, byte_in[3:0]);
					end else if (pos_q >= POS_W'(16) && cursor_q != CUR_DONE) begin
						// sample words run back to back from offset 16
						if (!pos_q[0]) begin
							high_q <= byte_in;
						end else begin
							case (cursor_q)
								3'd0: dword_q <= {high_q, byte_in};
								3'd1: analog_q[0] <= {high_q, byte_in};
								3'd2: analog_q[1] <= {high_q, byte_in};
								3'd3: analog_q[2] <= {high_q, byte_in};
								3'd4: analog_q[3] <= {high_q, byte_in};
								default: dword_q <= dword_q;
							endcase
							cursor_q <= find_field(cursor_q + 3'd1, dmask_q != 16'd0, amask_q);
						end
					end
					pos_q <= pos_next;
					if (17'(pos_next) >= 17'(frame_len_q)) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_q <= PH_HUNT;
				end
				PH_SKIP: begin
					skip_q <= skip_q - 17'd1;
					if (skip_q <= 17'd1) begin
						phase_q <= PH_HUNT;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

endmodule

// ----- src/rsfp_result.sv -----
// remote slot registers, address match, button decode and result register
module rsfp_result
	import rsfp_pkg::*;
#(
	parameter int REMOTE_SLOTS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   emit,
	input  frame_rec_t             frame,
	output logic                   out_free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   matched,
	output logic [1:0]             remote_slot,
	output logic [15:0]            stick_vertical,
	output logic [15:0]            stick_horizontal,
	output logic [15:0]            wheel_first,
	output logic [15:0]            wheel_second,
	output logic [4:0]             buttons_pressed
);

	localparam logic [REMOTE_COUNT_W-1:0] SLOTS_N = REMOTE_COUNT_W'(REMOTE_SLOTS);

	logic [REMOTE_COUNT_W-1:0] count_q;
	logic [31:0]               addr_q [REMOTE_SLOTS];
	logic [REMOTE_COUNT_W-1:0] count_eff;
	logic                      hit;
	logic [1:0]                slot;
	logic [4:0]                btn;

	// remote count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_index == CFG_REMOTE_COUNT) begin
			count_q <= cfg_data[REMOTE_COUNT_W-1:0];
		end
	end

	// remote address registers
	for (genvar i = 0; i < REMOTE_SLOTS; i++) begin : g_slot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				addr_q[i] <= '0;
			end else if (cfg_valid && cfg_index == CFG_REMOTE_ADDR_ZERO + CFG_INDEX_W'(i)) begin
				addr_q[i] <= cfg_data;
			end
		end
	end

	// lowest slot in use that matches the sender
	assign count_eff = (count_q > SLOTS_N) ? SLOTS_N : count_q;
	always_comb begin
		hit = 1'b0;
		slot = 2'd0;
		for (int i = REMOTE_SLOTS - 1; i >= 0; i--) begin
			if (REMOTE_COUNT_W'(i) < count_eff && addr_q[i] == frame.sender) begin
				hit = 1'b1;
				slot = 2'(i);
			end
		end
	end

	// active-low buttons
	assign btn = {~frame.digital_word[BTN_BIT_DIO4], ~frame.digital_word[BTN_BIT_DIO11],
		~frame.digital_word[BTN_BIT_DIO10], ~frame.digital_word[BTN_BIT_DIO6],
		~frame.digital_word[BTN_BIT_DIO5]};

	assign out_free = !out_valid || out_ready;

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			matched <= hit;
			remote_slot <= slot;
			stick_vertical <= frame.analog[0];
			stick_horizontal <= frame.analog[1];
			wheel_first <= frame.analog[2];
			wheel_second <= frame.analog[3];
			buttons_pressed <= btn;
		end
	end

endmodule

// ----- src/radio_io_sample_frame_parser.sv -----
// top level of the radio i/o sample frame parser
//
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | rx_byte
//  out     | out_valid / out_ready | matched, remote_slot, stick_*, wheel_*, buttons_pressed
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one byte a cycle while no result waits on a checksum byte: a byte is held in the input
// register, then the parser consumes it; a result appears in the output register the cycle after the checksum
// byte is parsed. reset clears the parse state, the remote registers and both
// valid flags. a waiting result stalls only a checksum byte that would make another
// result; all other bytes keep flowing. cfg_ready is always high.
module radio_io_sample_frame_parser
	import rsfp_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 64,
	parameter int REMOTE_SLOTS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   matched,
	output logic [1:0]             remote_slot,
	output logic [15:0]            stick_vertical,
	output logic [15:0]            stick_horizontal,
	output logic [15:0]            wheel_first,
	output logic [15:0]            wheel_second,
	output logic [4:0]             buttons_pressed,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       take;
	logic       emit;
	logic       out_free;
	frame_rec_t frame;

	assign cfg_ready = 1'b1;

	// input register
	rsfp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// frame parser
	rsfp_parser #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (valid_s1),
		.byte_in    (byte_s1),
		.out_free   (out_free),
		.take       (take),
		.emit       (emit),
		.frame      (frame)
	);

	// match, decode and result register
	rsfp_result #(
		.REMOTE_SLOTS (REMOTE_SLOTS)
	) u_result (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.emit             (emit),
		.frame            (frame),
		.out_free         (out_free),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.matched          (matched),
		.remote_slot      (remote_slot),
		.stick_vertical   (stick_vertical),
		.stick_horizontal (stick_horizontal),
		.wheel_first      (wheel_first),
		.wheel_second     (wheel_second),
		.buttons_pressed  (buttons_pressed)
	);

endmodule

// ----- dv/radio_io_sample_frame_parser_tb.sv -----
// self-checking testbench for the radio i/o sample frame parser
`timescale 1ns / 1ps

module radio_io_sample_frame_parser_tb;
	import rsfp_pkg::*;

	localparam int FRAME_CAP = 64;
	localparam int SLOT_COUNT = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int TOTAL_ITEMS = 1150;
	localparam int FIELD_DIGITAL = 0;
	localparam int FIELD_NONE = 5;

	typedef enum logic [2:0] {
		SCAN_DELIM, SCAN_LEN_HI, SCAN_LEN_LO, SCAN_BODY, SCAN_CHECK, SCAN_SKIP
	} scan_phase_t;

	typedef enum int {WORDS_RANDOM, WORDS_HIGH, WORDS_LOW} word_fill_t;

	typedef struct packed {
		logic        matched;
		logic [1:0]  slot;
		logic [15:0] vertical;
		logic [15:0] horizontal;
		logic [15:0] wheel_a;
		logic [15:0] wheel_b;
		logic [4:0]  buttons;
	} sample_report_t;

	typedef struct packed {
		logic [7:0] value;
		logic [2:0] gap;
	} rx_item_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [7:0]             rx_byte = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   matched;
	logic [1:0]             remote_slot;
	logic [15:0]            stick_vertical;
	logic [15:0]            stick_horizontal;
	logic [15:0]            wheel_first;
	logic [15:0]            wheel_second;
	logic [4:0]             buttons_pressed;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0]            cfg_data = '0;

	// traffic bookkeeping
	rx_item_t       rx_items[$];
	sample_report_t awaited_reports[$];
	int unsigned    bytes_queued = 0;
	int unsigned    bytes_taken = 0;
	int unsigned    send_idle = 0;
	int unsigned    mismatch_count = 0;
	bit             sender_eager = 1'b0;
	bit             sink_eager = 1'b0;
	bit             long_hold_go = 1'b0;
	logic           sink_hold = 1'b0;
	logic [2:0]     sink_wait = '0;

	// register shadow
	logic [REMOTE_COUNT_W-1:0] remote_count_cfg = '0;
	logic [31:0]               remote_addr_cfg [SLOT_COUNT] = '{default: '0};

	// parser shadow state
	scan_phase_t scan_phase = SCAN_DELIM;
	logic [15:0] frame_len = '0;
	logic [15:0] body_pos = '0;
	logic        kind_ok = 1'b0;
	logic [31:0] sender = '0;
	logic [15:0] dig_mask = '0;
	logic [3:0]  ana_mask = '0;
	logic [15:0] dig_word = '0;
	logic [15:0] analog [4] = '{default: '0};
	int unsigned word_at = 16;
	logic [7:0]  held_hi = '0;
	int unsigned skip_left = 0;
	int unsigned field_sel = FIELD_NONE;

	radio_io_sample_frame_parser #(
		.MAX_FRAME_BYTES(FRAME_CAP),
		.REMOTE_SLOTS(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched(matched),
		.remote_slot(remote_slot),
		.stick_vertical(stick_vertical),
		.stick_horizontal(stick_horizontal),
		.wheel_first(wheel_first),
		.wheel_second(wheel_second),
		.buttons_pressed(buttons_pressed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("radio_io_sample_frame_parser_tb failed");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// next field present in the frame, starting at the given one
	function automatic int unsigned next_present_field(input int unsigned from);
		for (int unsigned f = from; f < FIELD_NONE; f++) begin
			if (f == FIELD_DIGITAL) begin
				if (dig_mask != 0) return f;
			end else if (ana_mask[2'(f - 1)]) begin
				return f;
			end
		end
		return FIELD_NONE;
	endfunction

	// advance the parser shadow by one byte, queue the report it completes
	task automatic parse_rx_byte(input logic [7:0] b);
		sample_report_t rep;
		int unsigned pos;
		int unsigned n_slots;
		logic [15:0] w;
		case (scan_phase)
			SCAN_DELIM: begin
				if (b == FRAME_DELIM) scan_phase = SCAN_LEN_HI;
			end
			SCAN_LEN_HI: begin
				frame_len = {b, 8'h00};
				scan_phase = SCAN_LEN_LO;
			end
			SCAN_LEN_LO: begin
				frame_len[7:0] = b;
				if (frame_len == 0 || frame_len > FRAME_CAP) begin
					skip_left = frame_len + 1;
					scan_phase = SCAN_SKIP;
				end else begin
					body_pos = '0;
					kind_ok = 1'b0;
					sender = '0;
					dig_mask = '0;
					ana_mask = '0;
					dig_word = '0;
					analog[0] = ANALOG_DEFAULT_STICK;
					analog[1] = ANALOG_DEFAULT_STICK;
					analog[2] = ANALOG_DEFAULT_WHEEL;
					analog[3] = ANALOG_DEFAULT_WHEEL;
					word_at = 16;
					held_hi = '0;
					field_sel = FIELD_NONE;
					scan_phase = SCAN_BODY;
				end
			end
			SCAN_BODY: begin
				pos = 32'(body_pos);
				if (pos == 0) begin
					kind_ok = (b == FRAME_TYPE_IO_SAMPLE);
				end else if (pos >= 5 && pos <= 8) begin
					sender = {sender[23:0], b};
				end else if (pos == 13) begin
					dig_mask = {b, 8'h00};
				end else if (pos == 14) begin
					dig_mask[7:0] = b;
				end else if (pos == 15) begin
					ana_mask = b[3:0];
					word_at = 16;
					field_sel = next_present_field(FIELD_DIGITAL);
				end else if (pos >= 16 && field_sel < FIELD_NONE) begin
					if (pos == word_at) begin
						held_hi = b;
					end else if (pos == word_at + 1) begin
						w = {held_hi, b};
						if (field_sel == FIELD_DIGITAL) dig_word = w;
						else analog[2'(field_sel - 1)] = w;
						word_at = word_at + 2;
						field_sel = next_present_field(field_sel + 1);
					end
				end
				body_pos = 16'(pos + 1);
				if (body_pos >= frame_len) scan_phase = SCAN_CHECK;
			end
			SCAN_CHECK: begin
				scan_phase = SCAN_DELIM;
				// foreign, short and frames with a cut-off digital word give nothing
				if (kind_ok && frame_len >= MIN_SAMPLE_LEN
						&& !(dig_mask != 0 && field_sel == FIELD_DIGITAL)) begin
					n_slots = remote_count_cfg > SLOT_COUNT ? SLOT_COUNT : remote_count_cfg;
					rep = '0;
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (i < n_slots && !rep.matched && remote_addr_cfg[i] == sender) begin
							rep.matched = 1'b1;
							rep.slot = i[1:0];
						end
					end
					rep.vertical = analog[0];
					rep.horizontal = analog[1];
					rep.wheel_a = analog[2];
					rep.wheel_b = analog[3];
					// buttons are active low in the sample
					rep.buttons[0] = !dig_word[BTN_BIT_DIO5];
					rep.buttons[1] = !dig_word[BTN_BIT_DIO6];
					rep.buttons[2] = !dig_word[BTN_BIT_DIO10];
					rep.buttons[3] = !dig_word[BTN_BIT_DIO11];
					rep.buttons[4] = !dig_word[BTN_BIT_DIO4];
					awaited_reports.push_back(rep);
				end
			end
			SCAN_SKIP: begin
				if (skip_left > 0) skip_left--;
				if (skip_left == 0) scan_phase = SCAN_DELIM;
			end
			default: scan_phase = SCAN_DELIM;
		endcase
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin : byte_driver
		rx_item_t next_item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
			send_idle <= 0;
		end else begin
			if (in_valid && in_ready) begin
				parse_rx_byte(rx_byte);
				bytes_taken++;
			end
			// present the next item once the current one is gone
			if (!in_valid || in_ready) begin
				if (rx_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if (send_idle < rx_items[0].gap) begin
					in_valid <= 1'b0;
					send_idle <= send_idle + 1;
				end else begin
					next_item = rx_items.pop_front();
					in_valid <= 1'b1;
					rx_byte <= next_item.value;
					send_idle <= 0;
				end
			end
		end
	end

	// result monitor and sink stalls
	always @(posedge clk or negedge arst_n) begin : result_monitor
		sample_report_t want;
		logic [2:0] gap;
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_wait <= '0;
		end else begin
			gap = sink_wait;
			if (out_valid && out_ready) begin
				if (awaited_reports.size() == 0) begin
					flag_mismatch("result with none awaited", {31'b0, matched}, 32'b0);
				end else begin
					want = awaited_reports.pop_front();
					if (matched !== want.matched)
						flag_mismatch("matched", 32'(matched), 32'(want.matched));
					if (remote_slot !== want.slot)
						flag_mismatch("remote_slot", 32'(remote_slot), 32'(want.slot));
					if (stick_vertical !== want.vertical)
						flag_mismatch("stick_vertical", 32'(stick_vertical),
							32'(want.vertical));
					if (stick_horizontal !== want.horizontal)
						flag_mismatch("stick_horizontal", 32'(stick_horizontal),
							32'(want.horizontal));
					if (wheel_first !== want.wheel_a)
						flag_mismatch("wheel_first", 32'(wheel_first), 32'(want.wheel_a));
					if (wheel_second !== want.wheel_b)
						flag_mismatch("wheel_second", 32'(wheel_second), 32'(want.wheel_b));
					if (buttons_pressed !== want.buttons)
						flag_mismatch("buttons_pressed", 32'(buttons_pressed),
							32'(want.buttons));
				end
				gap = sink_eager ? 3'd0 : 3'($urandom_range(0, 4));
			end
			if (sink_hold) begin
				out_ready <= 1'b0;
			end else if (gap != 0) begin
				out_ready <= 1'b0;
				gap = gap - 3'd1;
			end else begin
				out_ready <= 1'b1;
			end
			sink_wait <= gap;
		end
	end

	// one long sink stall while frames keep coming
	initial begin : long_backpressure
		wait (long_hold_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	task automatic queue_byte(input logic [7:0] value);
		rx_item_t item;
		item.value = value;
		item.gap = sender_eager ? 3'd0 : 3'($urandom_range(0, 4));
		rx_items.push_back(item);
		bytes_queued++;
	endtask

	// bytes between frames, never a delimiter
	task automatic queue_noise(input int unsigned count);
		logic [7:0] v;
		for (int unsigned i = 0; i < count; i++) begin
			v = 8'($urandom_range(0, 255));
			queue_byte(v == FRAME_DELIM ? 8'h7F : v);
		end
	endtask

	function automatic int unsigned sample_body_len(input logic [15:0] dmask, input logic [7:0] amask);
		return 16 + (dmask != 0 ? 2 : 0) + 2 * $countones(amask[3:0]);
	endfunction

	task automatic queue_frame(input logic [7:0] kind, input logic [31:0] addr,
			input logic [15:0] dmask, input logic [7:0] amask, input int unsigned len,
			input word_fill_t fill, input logic [7:0] check_byte);
		logic [7:0] body [FRAME_CAP];
		for (int i = 0; i < FRAME_CAP; i++) begin
			if (i >= 16 && fill == WORDS_HIGH) body[i] = 8'hFF;
			else if (i >= 16 && fill == WORDS_LOW) body[i] = 8'h00;
			else body[i] = 8'($urandom_range(0, 255));
		end
		body[0] = kind;
		body[5] = addr[31:24];
		body[6] = addr[23:16];
		body[7] = addr[15:8];
		body[8] = addr[7:0];
		body[13] = dmask[15:8];
		body[14] = dmask[7:0];
		body[15] = amask;
		queue_byte(FRAME_DELIM);
		queue_byte(len[15:8]);
		queue_byte(len[7:0]);
		for (int unsigned i = 0; i < len; i++) queue_byte(body[i]);
		queue_byte(check_byte);
	endtask

	// zero or oversize length: length+1 bytes follow and are skipped
	task automatic queue_skipped_frame(input logic [15:0] len);
		queue_byte(FRAME_DELIM);
		queue_byte(len[15:8]);
		queue_byte(len[7:0]);
		for (int unsigned i = 0; i <= len; i++) queue_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic queue_random_frame(input bit tidy);
		logic [31:0] addr;
		logic [15:0] dmask;
		logic [7:0] amask;
		logic [7:0] kind;
		int unsigned natural_len;
		int unsigned len;
		int unsigned pick;
		addr = ($urandom_range(0, 3) != 0) ? remote_addr_cfg[2'($urandom_range(0, 3))]
			: $urandom();
		case ($urandom_range(0, 3))
			0: dmask = '0;
			1: dmask = 16'hFFFF;
			default: dmask = 16'($urandom());
		endcase
		amask = 8'($urandom_range(0, 255));
		natural_len = sample_body_len(dmask, amask);
		kind = FRAME_TYPE_IO_SAMPLE;
		len = natural_len;
		pick = tidy ? 0 : $urandom_range(0, 99);
		if (pick >= 60 && pick < 72) begin
			len = $urandom_range(16, natural_len);
		end else if (pick >= 72 && pick < 82) begin
			len = $urandom_range(natural_len, FRAME_CAP);
		end else if (pick >= 82 && pick < 88) begin
			kind = 8'($urandom_range(0, 255));
			if (kind == FRAME_TYPE_IO_SAMPLE) kind = kind + 8'd1;
			len = $urandom_range(16, 40);
		end else if (pick >= 88 && pick < 93) begin
			len = $urandom_range(1, 15);
		end
		if (pick >= 93) begin
			queue_skipped_frame($urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom_range(65, 160)));
		end else begin
			queue_frame(kind, addr, dmask, amask, len, WORDS_RANDOM,
				8'($urandom_range(0, 255)));
		end
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (index == CFG_REMOTE_COUNT)
			remote_count_cfg = value[REMOTE_COUNT_W-1:0];
		else if (index >= CFG_REMOTE_ADDR_ZERO && index <= CFG_REMOTE_ADDR_THREE)
			remote_addr_cfg[2'(index - CFG_REMOTE_ADDR_ZERO)] = value;
	endtask

	task automatic write_remotes(input logic [2:0] count, input logic [31:0] a0,
			input logic [31:0] a1, input logic [31:0] a2, input logic [31:0] a3);
		write_register(CFG_REMOTE_COUNT, ($urandom() & ~32'h7) | {29'b0, count});
		write_register(CFG_REMOTE_ADDR_ZERO, a0);
		write_register(CFG_REMOTE_ADDR_ONE, a1);
		write_register(CFG_REMOTE_ADDR_TWO, a2);
		write_register(CFG_REMOTE_ADDR_THREE, a3);
	endtask

	// wait for every byte to go in and every report to come out
	task automatic wait_until_drained();
		@(posedge clk);
		while (bytes_taken != bytes_queued || awaited_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// stimulus
	initial begin : stimulus
		logic [31:0] addr_x;
		logic [31:0] addr_y;
		logic [31:0] picks [SLOT_COUNT];
		int unsigned phase;
		int unsigned n_frames;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// slots at the address extremes
		addr_x = $urandom();
		write_remotes(3'd4, 32'h0000_0000, 32'hFFFF_FFFF, addr_x, ~addr_x);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h7F);
		// shortest sample frame: no masks, all buttons pressed, default analogs
		queue_frame(FRAME_TYPE_IO_SAMPLE, 32'h0, 16'h0, 8'h00, 16, WORDS_RANDOM, 8'h00);
		// every field present, words at both extremes
		queue_frame(FRAME_TYPE_IO_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 8'h0F, 26, WORDS_HIGH, 8'hFF);
		queue_frame(FRAME_TYPE_IO_SAMPLE, ~addr_x, 16'h0001, 8'hFF, 26, WORDS_LOW, 8'h00);
		// digital word missing or cut in half
		queue_frame(FRAME_TYPE_IO_SAMPLE, addr_x, 16'h0030, 8'h0F, 16, WORDS_RANDOM, 8'h11);
		queue_frame(FRAME_TYPE_IO_SAMPLE, addr_x, 16'h0030, 8'h0F, 17, WORDS_RANDOM, 8'h22);
		// analog list cut short
		queue_frame(FRAME_TYPE_IO_SAMPLE, addr_x, 16'h0C70, 8'h0F, 21, WORDS_RANDOM, 8'h33);
		queue_frame(FRAME_TYPE_IO_SAMPLE, addr_x, 16'h0000, 8'h0A, 18, WORDS_RANDOM, 8'h44);
		// padded to the largest body
		queue_frame(FRAME_TYPE_IO_SAMPLE, 32'h0, 16'h0810, 8'hA5, FRAME_CAP, WORDS_RANDOM, 8'h55);
		// zero and just-oversize lengths, short and foreign frames
		queue_skipped_frame(16'd0);
		queue_skipped_frame(16'(FRAME_CAP + 1));
		queue_frame(FRAME_TYPE_IO_SAMPLE, 32'h0, 16'h0, 8'h0, 15, WORDS_RANDOM, 8'h66);
		queue_frame(8'h91, 32'h0, 16'h0, 8'h0, 20, WORDS_RANDOM, 8'h77);
		// delimiters inside the body and as checksum
		queue_frame(FRAME_TYPE_IO_SAMPLE, 32'h7E7E_7E7E, 16'h7E7E, 8'h7E, 26, WORDS_RANDOM,
			FRAME_DELIM);
		queue_frame(FRAME_TYPE_IO_SAMPLE, 32'h5A5A_5A5A, 16'h0040, 8'h03, 22, WORDS_RANDOM, 8'h88);
		queue_frame(FRAME_TYPE_IO_SAMPLE, 32'hFFFF_FFFF, 16'h0400, 8'h01, 20, WORDS_RANDOM, 8'h99);
		wait_until_drained();

		// count above slot number, repeated addresses pick the lowest slot
		addr_x = $urandom();
		addr_y = ~addr_x;
		write_remotes(3'd7, addr_x, addr_x, addr_x, addr_y);
		queue_frame(FRAME_TYPE_IO_SAMPLE, addr_y, 16'h0, 8'h0, 16, WORDS_RANDOM, 8'h01);
		queue_frame(FRAME_TYPE_IO_SAMPLE, addr_x, 16'h0, 8'h0, 16, WORDS_RANDOM, 8'h02);
		wait_until_drained();
		// no slots in use, then a match beyond the count
		write_remotes(3'd0, 32'h0, addr_x, addr_x, addr_y);
		queue_frame(FRAME_TYPE_IO_SAMPLE, 32'h0, 16'h0, 8'h0, 16, WORDS_RANDOM, 8'h03);
		wait_until_drained();
		write_register(CFG_REMOTE_COUNT, 32'd2);
		queue_frame(FRAME_TYPE_IO_SAMPLE, addr_y, 16'h0, 8'h0, 16, WORDS_RANDOM, 8'h04);
		wait_until_drained();

		// random phases, each under its own slot setting
		phase = 0;
		while (bytes_queued < TOTAL_ITEMS || phase < 3) begin
			for (int i = 0; i < SLOT_COUNT; i++) picks[i] = $urandom();
			if ($urandom_range(0, 2) == 0) picks[2'($urandom_range(1, 3))] = picks[0];
			if (phase == 0)
				write_remotes(3'd7, 32'hFFFF_FFFF, 32'h0, picks[2], picks[3]);
			else
				write_remotes(3'($urandom_range(0, 7)), picks[0], picks[1], picks[2], picks[3]);
			sender_eager = ($urandom_range(0, 3) == 0);
			sink_eager = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				// dense burst against a long sink stall
				sender_eager = 1'b1;
				for (int k = 0; k < 14; k++) queue_random_frame(1'b1);
				long_hold_go = 1'b1;
			end else begin
				n_frames = $urandom_range(5, 10);
				for (int unsigned k = 0; k < n_frames; k++) begin
					if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 4));
					queue_random_frame(1'b0);
				end
			end
			wait_until_drained();
			phase++;
		end

		if (mismatch_count == 0) begin
			$display("radio_io_sample_frame_parser_tb passed");
		end else begin
			$display("radio_io_sample_frame_parser_tb failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/rsfp_pkg.sv
src/rsfp_in_reg.sv
src/rsfp_parser.sv
src/rsfp_result.sv
src/radio_io_sample_frame_parser.sv
dv/radio_io_sample_frame_parser_tb.sv
